>>> design/bldc_pkg.sv
// shared constants and types for the six-step throttle commutator
package bldc_pkg;

    // moving average window, a power of two, and raw sample width
    localparam int WINDOW       = 256;
    localparam int SAMPLE_BITS  = 12;
    localparam int IDX_BITS     = $clog2(WINDOW);
    localparam int SUM_BITS     = SAMPLE_BITS + IDX_BITS;

    // duty and compare width, multiplier product width
    localparam int PWM_BITS     = 16;
    localparam int PROD_BITS    = SAMPLE_BITS + PWM_BITS;
    localparam int DCNT_BITS    = $clog2(PWM_BITS);

    // channel and configuration port widths
    localparam int S_DATA_BITS  = 16;
    localparam int M_DATA_BITS  = 72;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    // configuration register reset values
    localparam logic [SAMPLE_BITS-1:0] THROTTLE_MAX_RST = SAMPLE_BITS'(3560);
    localparam logic [PWM_BITS-1:0]    PWM_MAX_RST      = PWM_BITS'(3599);
    localparam logic [PWM_BITS-1:0]    LOW_CMP_RST      = PWM_BITS'(3599);

    // configuration register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_THROTTLE_MIN = 3'd0,
        CFG_THROTTLE_MAX = 3'd1,
        CFG_PWM_MIN      = 3'd2,
        CFG_PWM_MAX      = 3'd3,
        CFG_LOW_CMP      = 3'd4
    } cfg_idx_t;

    // hall codes of the six commutation steps (high phase, low phase)
    localparam logic [2:0] HALL_A_B = 3'b101;
    localparam logic [2:0] HALL_A_C = 3'b100;
    localparam logic [2:0] HALL_B_C = 3'b110;
    localparam logic [2:0] HALL_B_A = 3'b010;
    localparam logic [2:0] HALL_C_A = 3'b011;
    localparam logic [2:0] HALL_C_B = 3'b001;

    // phase enable masks
    localparam logic [2:0] PH_A = 3'b001;
    localparam logic [2:0] PH_B = 3'b010;
    localparam logic [2:0] PH_C = 3'b100;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SUM   = 6'b000010,
        ST_CLAMP = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

>>> design/bldc_six_step_throttle_commutator_top.sv
// six-step commutator with boxcar-filtered throttle and iterative duty divider
//
//  channel   ports              contents (low bit up)
//  input     s_tvalid/tready    s_tdata: throttle_sample[11:0], hall_code[14:12]
//  result    m_tvalid/tready    m_tdata: compare_a, compare_b, compare_c, high_enable,
//                               low_enable, dead_time_gap, hall_fault, filtered_throttle
//  config    cfg_we/addr/wdata  five registers
//
// an item passes from acceptance through one ring read, one sum update, one clamp, one
// multiply and 16 steps of the shared restoring subtractor that divides by the throttle
// span, then a step to form the result; no new item is taken until the result is formed.
// reset clears the sequencer, index, sum and hall state; the sample ring needs no
// clearing pass, a wrap flag makes unwritten entries read as zero.
// a result waiting in the output register stalls only the final cycle of the next item.
module bldc_six_step_throttle_commutator_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // throttle_sample[11:0], hall_code[14:12], zero[15]
    input  logic [bldc_pkg::S_DATA_BITS-1:0]     s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // compare_a[15:0], compare_b[31:16], compare_c[47:32], high_enable[50:48],
    // low_enable[53:51], dead_time_gap[54], hall_fault[55],
    // filtered_throttle[67:56], zero[71:68]
    output logic [bldc_pkg::M_DATA_BITS-1:0]     m_tdata,
    input  logic                                 cfg_we,
    input  logic [bldc_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [bldc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import bldc_pkg::*;

    // configuration registers
    logic [SAMPLE_BITS-1:0] tmin_reg, tmax_reg;
    logic [PWM_BITS-1:0]    pmin_reg, pmax_reg, lcmp_reg;

    // sequencer and item state
    state_t                 state_reg, state_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [2:0]             hall_reg;
    logic [IDX_BITS-1:0]    idx_reg;
    logic                   wrapped_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic [SAMPLE_BITS:0]   rem_reg;
    logic [PWM_BITS-1:0]    quo_reg;
    logic [DCNT_BITS-1:0]   cnt_reg;
    logic [2:0]             last_hall_reg;
    logic                   last_valid_reg;

    // sample ring
    logic [SAMPLE_BITS-1:0] ring [WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    // output register
    logic                   m_valid_reg;
    logic [PWM_BITS-1:0]    cmp_a_reg, cmp_b_reg, cmp_c_reg;
    logic [2:0]             hi_en_reg, lo_en_reg;
    logic                   gap_reg, fault_reg;
    logic [SAMPLE_BITS-1:0] filt_reg;

    logic                   s_acc, load_out;
    logic [SAMPLE_BITS-1:0] span, delta, avg_raw, avg_clamped, old_sample;
    logic                   span_empty, rising;
    logic [PWM_BITS-1:0]    mag, duty;
    logic [PROD_BITS-1:0]   product;
    logic [SAMPLE_BITS:0]   shifted;
    logic [SAMPLE_BITS+1:0] diff;
    logic                   borrow;
    logic [2:0]             hi_sel, lo_sel;
    logic                   fault;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tmin_reg <= '0;
            tmax_reg <= THROTTLE_MAX_RST;
            pmin_reg <= '0;
            pmax_reg <= PWM_MAX_RST;
            lcmp_reg <= LOW_CMP_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_THROTTLE_MIN: tmin_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                CFG_THROTTLE_MAX: tmax_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                CFG_PWM_MIN:      pmin_reg <= cfg_wdata[PWM_BITS-1:0];
                CFG_PWM_MAX:      pmax_reg <= cfg_wdata[PWM_BITS-1:0];
                CFG_LOW_CMP:      lcmp_reg <= cfg_wdata[PWM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ring memory: written in the sum step, read at the write index
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SUM) begin
            ring[idx_reg] <= sample_reg;
        end
        rd_data_reg <= ring[idx_reg];
    end

    // mapping terms shared by several steps
    assign span       = tmax_reg - tmin_reg;
    assign span_empty = (tmax_reg <= tmin_reg);
    assign rising     = (pmax_reg >= pmin_reg);
    assign mag        = rising ? (pmax_reg - pmin_reg) : (pmin_reg - pmax_reg);
    assign delta      = avg_reg - tmin_reg;
    assign product    = PROD_BITS'(delta) * PROD_BITS'(mag);
    assign old_sample = wrapped_reg ? rd_data_reg : '0;

    // clamp against max first, then min
    assign avg_raw = sum_reg[SUM_BITS-1:IDX_BITS];
    always_comb begin
        if (avg_raw > tmax_reg) begin
            avg_clamped = tmax_reg;
        end else if (avg_raw < tmin_reg) begin
            avg_clamped = tmin_reg;
        end else begin
            avg_clamped = avg_raw;
        end
    end

    // one restoring division step
    assign shifted = {rem_reg[SAMPLE_BITS-1:0], quo_reg[PWM_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, span};
    assign borrow  = diff[SAMPLE_BITS+1];

    // duty from the quotient
    always_comb begin
        if (span_empty) begin
            duty = pmin_reg;
        end else if (rising) begin
            duty = pmin_reg + quo_reg;
        end else begin
            duty = pmin_reg - quo_reg;
        end
    end

    // commutation step decode
    always_comb begin
        hi_sel = '0;
        lo_sel = '0;
        case (hall_reg)
            HALL_A_B: begin hi_sel = PH_A; lo_sel = PH_B; end
            HALL_A_C: begin hi_sel = PH_A; lo_sel = PH_C; end
            HALL_B_C: begin hi_sel = PH_B; lo_sel = PH_C; end
            HALL_B_A: begin hi_sel = PH_B; lo_sel = PH_A; end
            HALL_C_A: begin hi_sel = PH_C; lo_sel = PH_A; end
            HALL_C_B: begin hi_sel = PH_C; lo_sel = PH_B; end
            default:  begin hi_sel = '0;   lo_sel = '0;   end
        endcase
    end
    assign fault = (hi_sel == 3'b000);

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_acc) state_next = ST_SUM;
            ST_SUM:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_MUL;
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == '0) state_next = ST_DONE;
            ST_DONE:  if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            wrapped_reg    <= 1'b0;
            sum_reg        <= '0;
            last_hall_reg  <= '0;
            last_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SUM) begin
                sum_reg <= sum_reg - SUM_BITS'(old_sample) + SUM_BITS'(sample_reg);
                if (idx_reg == IDX_BITS'(WINDOW - 1)) begin
                    idx_reg     <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (load_out && !fault) begin
                last_hall_reg  <= hall_reg;
                last_valid_reg <= 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            hall_reg   <= s_tdata[SAMPLE_BITS+2:SAMPLE_BITS];
        end
        if (state_reg == ST_CLAMP) begin
            avg_reg <= avg_clamped;
        end
        if (state_reg == ST_MUL) begin
            rem_reg <= (SAMPLE_BITS+1)'(product[PROD_BITS-1:PWM_BITS]);
            quo_reg <= product[PWM_BITS-1:0];
            cnt_reg <= DCNT_BITS'(PWM_BITS - 1);
        end
        if (state_reg == ST_DIV) begin
            rem_reg <= borrow ? shifted : diff[SAMPLE_BITS:0];
            quo_reg <= {quo_reg[PWM_BITS-2:0], ~borrow};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (load_out) begin
            cmp_a_reg <= fault ? '0 : (hi_sel[0] ? duty : (lo_sel[0] ? lcmp_reg : '0));
            cmp_b_reg <= fault ? '0 : (hi_sel[1] ? duty : (lo_sel[1] ? lcmp_reg : '0));
            cmp_c_reg <= fault ? '0 : (hi_sel[2] ? duty : (lo_sel[2] ? lcmp_reg : '0));
            hi_en_reg <= hi_sel;
            lo_en_reg <= lo_sel;
            gap_reg   <= fault || !last_valid_reg || (hall_reg != last_hall_reg);
            fault_reg <= fault;
            filt_reg  <= avg_reg;
        end
    end

    // result channel
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, filt_reg, fault_reg, gap_reg, lo_en_reg, hi_en_reg,
                       cmp_c_reg, cmp_b_reg, cmp_a_reg};

`ifndef SYNTH
    // an accepted item blocks the input until its work is done
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // divider remainder stays below the span
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) && !span_empty |-> rem_reg < {1'b0, span})
        else $error("divider remainder out of range");

    // enables are each at most one phase and never the same phase
    a_enables: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(hi_en_reg) && $onehot0(lo_en_reg)
                     && ((hi_en_reg & lo_en_reg) == 3'b000))
        else $error("bad phase enables");

    // a hall fault shuts everything off and flags a gap
    a_fault_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && fault_reg |-> gap_reg && (hi_en_reg == 3'b000)
                                  && (lo_en_reg == 3'b000))
        else $error("fault result not disabled");
`endif

endmodule
